@@ rtl/bitmap_page_frame_allocator_defines.svh @@
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication check
`define BPFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpfa check failed");

// next-cycle implication check
`define BPFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpfa check failed");

`endif

@@ rtl/bpfa_pkg.sv @@
`default_nettype none
package bpfa_pkg;

  localparam int MAX_PAGES_DEF = 4096;
  localparam int MAX_GRANT_DEF = 16;

  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  // one memory word: 8 in-use bits low, 8 reserved bits high
  localparam int WORD_PAGES = 8;
  localparam int BIT_W      = 3;
  localparam int MEM_W      = 2 * WORD_PAGES;
  localparam logic [MEM_W-1:0] WORD_ONES = {MEM_W{1'b1}};

  localparam logic [CNT_W-1:0] ACTIVE_RST = 13'd4096;

  localparam logic [OP_W-1:0] OP_SET_RANGE = 3'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd2;
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_HINT  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_ACQ  = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD      = 3'd5;

  typedef struct packed {
    logic             en;
    logic [MEM_W-1:0] data;
  } mem_wr_t;

endpackage
`default_nettype wire

@@ rtl/bitmap_page_frame_allocator.sv @@
// Set range reads, then rewrites, each page; release, reserve and query read, then test.
// Acquire reads, then tests, each page from the start page on; then each granted page is
// read again and its in-use bit written back, then its result is sent.
// One request at a time; the next request is taken once the last result is taken.
// Reset (rst_n low, synchronous): a clearing pass over all MAX_PAGES/8 words sets both maps
// to all ones; no request is taken until it ends. Hint resets to 0, active_pages to 4096.
`default_nettype none
`include "bitmap_page_frame_allocator_defines.svh"
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int MAX_GRANT = MAX_GRANT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // page[11:0], count[24:12], dense[25], use_hint[26], mark_unavailable[27], zero[31:28]
  input  wire logic [31:0]      in_tdata,
  // operation[2:0]
  input  wire logic [OP_W-1:0]  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[2:0], granted_page[14:3], reserved_flag[15], used_flag[16], zero[23:17]
  output logic      [23:0]      out_tdata,
  output logic                  out_tlast,
  // active_pages register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_PAGES / WORD_PAGES;
  localparam int AW    = $clog2(DEPTH);
  // page arithmetic width: holds page + count without overflow
  localparam int PGW   = ($clog2(MAX_PAGES) + 1 > CNT_W + 1) ? $clog2(MAX_PAGES) + 1 : CNT_W + 1;
  localparam int KW    = $clog2(MAX_GRANT + 1);
  localparam int GW    = (MAX_GRANT > 1) ? $clog2(MAX_GRANT) : 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_GRD   = 7'b0010000,
    S_GWR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]  act_r;
  logic [PAGE_W-1:0] hint_r, hint_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic              dense_r, dense_nxt;
  logic              mark_r, mark_nxt;
  logic [PAGE_W-1:0] orig_r, orig_nxt;
  logic [PGW-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [PGW-1:0]    n_r, n_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     want_r, want_nxt;
  logic [GW-1:0]     gi_r, gi_nxt;
  logic [PGW-1:0]    last_r, last_nxt;
  logic [PGW-1:0]    got_r [MAX_GRANT];
  logic              got_we;
  logic [GW-1:0]     got_idx;

  logic              ov_r, ov_nxt;
  logic [ST_W-1:0]   os_r, os_nxt;
  logic [PAGE_W-1:0] opg_r, opg_nxt;
  logic              olast_r, olast_nxt;
  logic              orsv_r, orsv_nxt;
  logic              oused_r, oused_nxt;

  mem_wr_t           mw;
  logic [AW-1:0]     waddr;
  logic [MEM_W-1:0]  rdata;
  logic [MEM_W-1:0]  wd;

  // request fields
  logic [PAGE_W-1:0] f_page;
  logic [CNT_W-1:0]  f_count;
  logic              f_dense, f_use_hint, f_mark;
  logic [PGW-1:0]    lim, page_x, start_x, cur_inc, cur_wrap;
  logic [BIT_W-1:0]  rbit;
  logic              used_b, rsv_b, free_b, gap_b, in_acc, out_acc;
  logic [KW-1:0]     k_new, k_base;
  logic [PGW-1:0]    n_inc;

  assign f_page     = in_tdata[11:0];
  assign f_count    = in_tdata[24:12];
  assign f_dense    = in_tdata[25];
  assign f_use_hint = in_tdata[26];
  assign f_mark     = in_tdata[27];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = ov_r && out_tready;

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {7'd0, oused_r, orsv_r, opg_r, os_r};

  // effective page limit: active_pages clamped to the map size
  assign lim = (PGW'(act_r) > PGW'(MAX_PAGES)) ? PGW'(MAX_PAGES) : PGW'(act_r);

  assign page_x   = PGW'(f_page);
  assign start_x  = f_use_hint ? page_x : PGW'(hint_r);
  assign cur_inc  = cur_r + PGW'(1);
  assign cur_wrap = (cur_inc >= lim) ? '0 : cur_inc;

  assign rbit   = cur_r[BIT_W-1:0];
  assign used_b = rdata[{1'b0, rbit}];
  assign rsv_b  = rdata[{1'b1, rbit}];
  assign free_b = !used_b && !rsv_b;

  // dense mode: restart the run when this page does not follow the last one
  assign gap_b  = (k_r != '0) && dense_r && (last_r + PGW'(1) != cur_r);
  assign k_base = gap_b ? '0 : k_r;
  assign k_new  = free_b ? k_base + KW'(1) : k_r;
  assign n_inc  = n_r + PGW'(1);

  bpfa_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .wr    (mw),
    .waddr (waddr),
    .raddr (cur_r[AW+BIT_W-1:BIT_W]),
    .rdata (rdata)
  );

  assign waddr = (state_r == S_CLEAR) ? clr_r : cur_r[AW+BIT_W-1:BIT_W];

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    hint_nxt  = hint_r;
    op_nxt    = op_r;
    dense_nxt = dense_r;
    mark_nxt  = mark_r;
    orig_nxt  = orig_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    want_nxt  = want_r;
    gi_nxt    = gi_r;
    last_nxt  = last_r;
    got_we    = 1'b0;
    got_idx   = GW'(k_base);
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    opg_nxt   = opg_r;
    olast_nxt = olast_r;
    orsv_nxt  = orsv_r;
    oused_nxt = oused_r;
    wd        = rdata;
    mw.en     = 1'b0;
    mw.data   = rdata;

    unique case (state_r)
      S_CLEAR: begin
        mw.en   = 1'b1;
        mw.data = WORD_ONES;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          dense_nxt = f_dense;
          mark_nxt  = f_mark;
          orig_nxt  = f_page;
          cur_nxt   = page_x;
          rem_nxt   = f_count;
          // default: single result, done, with the request page
          os_nxt    = ST_DONE;
          opg_nxt   = f_page;
          olast_nxt = 1'b1;
          orsv_nxt  = 1'b0;
          oused_nxt = 1'b0;
          case (in_tuser) inside
            OP_SET_RANGE: begin
              if (page_x + PGW'(f_count) > lim) begin
                os_nxt = ST_RANGE;
              end else begin
                if (!f_mark && hint_r == '0) begin
                  hint_nxt = f_page;
                end
                if (f_count != '0) begin
                  state_nxt = S_RD;
                end
              end
            end
            OP_ACQUIRE: begin
              orig_nxt = start_x[PAGE_W-1:0];
              opg_nxt  = start_x[PAGE_W-1:0];
              cur_nxt  = start_x;
              n_nxt    = '0;
              k_nxt    = '0;
              want_nxt = (f_count > CNT_W'(MAX_GRANT)) ? KW'(MAX_GRANT) : KW'(f_count);
              if (f_count == '0) begin
                os_nxt = ST_BAD;
              end else if (start_x >= lim) begin
                os_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            OP_RELEASE, OP_RESERVE, OP_QUERY: begin
              if (page_x >= lim) begin
                os_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            OP_SET_HINT: begin
              if (page_x >= lim) begin
                os_nxt = ST_RANGE;
              end else begin
                hint_nxt = f_page;
              end
            end
            default: os_nxt = ST_BAD;
          endcase
          if (state_nxt == S_IDLE) begin
            ov_nxt    = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end

      S_RD: state_nxt = S_EVAL;

      S_EVAL: begin
        os_nxt    = ST_DONE;
        opg_nxt   = orig_r;
        olast_nxt = 1'b1;
        orsv_nxt  = 1'b0;
        oused_nxt = 1'b0;
        ov_nxt    = 1'b1;
        state_nxt = S_OUT;
        case (op_r)
          OP_SET_RANGE: begin
            wd[{1'b0, rbit}] = mark_r;
            wd[{1'b1, rbit}] = mark_r;
            mw.en   = 1'b1;
            mw.data = wd;
            cur_nxt = cur_inc;
            rem_nxt = rem_r - CNT_W'(1);
            if (rem_r != CNT_W'(1)) begin
              ov_nxt    = 1'b0;
              state_nxt = S_RD;
            end
          end
          OP_RELEASE: begin
            if (rsv_b) begin
              os_nxt = ST_RESERVED;
            end else if (!used_b) begin
              os_nxt = ST_NOT_ACQ;
            end else begin
              wd[{1'b0, rbit}] = 1'b0;
              mw.en   = 1'b1;
              mw.data = wd;
            end
          end
          OP_RESERVE: begin
            if (!used_b) begin
              os_nxt = ST_NOT_ACQ;
            end else begin
              wd[{1'b1, rbit}] = 1'b1;
              mw.en   = 1'b1;
              mw.data = wd;
            end
          end
          OP_QUERY: begin
            orsv_nxt  = rsv_b;
            oused_nxt = used_b;
          end
          default: begin
            // acquire scan, one page per visit
            ov_nxt    = 1'b0;
            state_nxt = S_RD;
            if (free_b) begin
              got_we   = 1'b1;
              last_nxt = cur_r;
            end
            k_nxt   = k_new;
            n_nxt   = n_inc;
            cur_nxt = cur_wrap;
            if (n_inc == lim || k_new == want_r) begin
              if (k_new == '0) begin
                os_nxt    = ST_NONE;
                ov_nxt    = 1'b1;
                state_nxt = S_OUT;
              end else begin
                gi_nxt    = '0;
                cur_nxt   = (free_b && k_base == '0) ? cur_r : got_r[0];
                state_nxt = S_GRD;
              end
            end
          end
        endcase
      end

      S_GRD: state_nxt = S_GWR;

      S_GWR: begin
        wd[{1'b0, rbit}] = 1'b1;
        mw.en     = 1'b1;
        mw.data   = wd;
        os_nxt    = ST_DONE;
        opg_nxt   = cur_r[PAGE_W-1:0];
        olast_nxt = (KW'(gi_r) + KW'(1) == k_r);
        orsv_nxt  = 1'b0;
        oused_nxt = 1'b0;
        ov_nxt    = 1'b1;
        if (KW'(gi_r) + KW'(1) == k_r) begin
          hint_nxt = cur_wrap[PAGE_W-1:0];
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_acc) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else begin
            gi_nxt    = gi_r + GW'(1);
            cur_nxt   = got_r[gi_r + GW'(1)];
            state_nxt = S_GRD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      hint_r  <= '0;
      act_r   <= ACTIVE_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hint_r  <= hint_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        act_r <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    dense_r <= dense_nxt;
    mark_r  <= mark_nxt;
    orig_r  <= orig_nxt;
    cur_r   <= cur_nxt;
    rem_r   <= rem_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    want_r  <= want_nxt;
    gi_r    <= gi_nxt;
    last_r  <= last_nxt;
    os_r    <= os_nxt;
    opg_r   <= opg_nxt;
    olast_r <= olast_nxt;
    orsv_r  <= orsv_nxt;
    oused_r <= oused_nxt;
    if (got_we) begin
      got_r[got_idx] <= cur_r;
    end
  end

  `BPFA_ASSERT_IMP(a_ready_no_result, in_tready, !out_tvalid)
  `BPFA_ASSERT_IMP(a_clear_blocks, state_r == S_CLEAR, !in_tready && !out_tvalid)
  `BPFA_ASSERT_IMP(a_grant_index, state_r == S_GWR, KW'(gi_r) < k_r)
  `BPFA_ASSERT_NXT(a_grant_seq, state_r == S_GRD, state_r == S_GWR)

endmodule
`default_nettype wire

@@ rtl/bpfa_map_mem.sv @@
`default_nettype none
module bpfa_map_mem import bpfa_pkg::*; #(
  parameter int DEPTH = MAX_PAGES_DEF / WORD_PAGES,
  parameter int AW    = $clog2(MAX_PAGES_DEF / WORD_PAGES)
) (
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [AW-1:0]    raddr,
  output logic      [MEM_W-1:0] rdata
);

  logic [MEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ verif/bpfa_checker.sv @@
`default_nettype none
module bpfa_checker import bpfa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [31:0]      in_tdata,
  input  wire logic [OP_W-1:0]  in_tuser,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [23:0]      out_tdata,
  input  wire logic             out_tlast,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [PAGE_W-1:0] page;
    logic              last;
    logic              rsv;
    logic              used;
  } grant_t;

  logic            used_map [4096];
  logic            rsv_map  [4096];
  logic [11:0]     hint;
  logic [12:0]     n_active;
  grant_t          expected_grants[$];

  assign pending = expected_grants.size();

  function automatic int lim_pages();
    return (n_active > 13'd4096) ? 4096 : int'(n_active);
  endfunction

  function automatic void post(logic [2:0] st, logic [11:0] pg, logic l, logic r, logic u);
    grant_t g;
    g.status = st; g.page = pg; g.last = l; g.rsv = r; g.used = u;
    expected_grants.push_back(g);
  endfunction

  task automatic run_acquire(int start, int want, logic dense);
    int lim, n, p, k;
    int got[16];
    lim = lim_pages();
    k = 0;
    if (want == 0) begin
      post(ST_BAD, start[11:0], 1, 0, 0);
      return;
    end
    if (want > 16) want = 16;
    if (start >= lim) begin
      post(ST_RANGE, start[11:0], 1, 0, 0);
      return;
    end
    for (n = 0; n < lim && k < want; n++) begin
      p = start + n;
      if (p >= lim) p -= lim;
      if (used_map[p] || rsv_map[p]) continue;
      if (k != 0 && dense && got[k-1] + 1 != p) k = 0;
      got[k++] = p;
    end
    if (k == 0) begin
      post(ST_NONE, start[11:0], 1, 0, 0);
      return;
    end
    for (n = 0; n < k; n++) begin
      used_map[got[n]] = 1'b1;
      post(ST_DONE, got[n][11:0], n + 1 == k, 0, 0);
    end
    p = got[k-1] + 1;
    hint = (p >= lim) ? 12'd0 : p[11:0];
  endtask

  task automatic predict(logic [2:0] op, logic [31:0] d);
    int pg, cnt, lim;
    logic dense, use_h, mark;
    pg = d[11:0]; cnt = d[24:12]; dense = d[25]; use_h = d[26]; mark = d[27];
    lim = lim_pages();
    case (op)
      OP_SET_RANGE: begin
        if (pg + cnt > lim) post(ST_RANGE, pg[11:0], 1, 0, 0);
        else begin
          if (!mark && hint == 0) hint = pg[11:0];
          for (int i = 0; i < cnt; i++) begin
            used_map[(pg + i) % 4096] = mark;
            rsv_map[(pg + i) % 4096] = mark;
          end
          post(ST_DONE, pg[11:0], 1, 0, 0);
        end
      end
      OP_ACQUIRE: run_acquire(use_h ? pg : int'(hint), cnt, dense);
      OP_RELEASE: begin
        if (pg >= lim) post(ST_RANGE, pg[11:0], 1, 0, 0);
        else if (rsv_map[pg]) post(ST_RESERVED, pg[11:0], 1, 0, 0);
        else if (!used_map[pg]) post(ST_NOT_ACQ, pg[11:0], 1, 0, 0);
        else begin
          used_map[pg] = 1'b0;
          post(ST_DONE, pg[11:0], 1, 0, 0);
        end
      end
      OP_RESERVE: begin
        if (pg >= lim) post(ST_RANGE, pg[11:0], 1, 0, 0);
        else if (!used_map[pg]) post(ST_NOT_ACQ, pg[11:0], 1, 0, 0);
        else begin
          rsv_map[pg] = 1'b1;
          post(ST_DONE, pg[11:0], 1, 0, 0);
        end
      end
      OP_SET_HINT: begin
        if (pg >= lim) post(ST_RANGE, pg[11:0], 1, 0, 0);
        else begin
          hint = pg[11:0];
          post(ST_DONE, pg[11:0], 1, 0, 0);
        end
      end
      OP_QUERY: begin
        if (pg >= lim) post(ST_RANGE, pg[11:0], 1, 0, 0);
        else post(ST_DONE, pg[11:0], 1, rsv_map[pg], used_map[pg]);
      end
      default: post(ST_BAD, pg[11:0], 1, 0, 0);
    endcase
  endtask

  task automatic compare(grant_t e, grant_t a);
    if (e.status !== a.status) begin
      $error("status: expected %0d actual %0d", e.status, a.status); fail_count++;
    end
    if (e.page !== a.page) begin
      $error("granted_page: expected %0d actual %0d", e.page, a.page); fail_count++;
    end
    if (e.last !== a.last) begin
      $error("last: expected %0d actual %0d", e.last, a.last); fail_count++;
    end
    if (e.rsv !== a.rsv) begin
      $error("reserved_flag: expected %0d actual %0d", e.rsv, a.rsv); fail_count++;
    end
    if (e.used !== a.used) begin
      $error("used_flag: expected %0d actual %0d", e.used, a.used); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    hint = '0;
    n_active = 13'd4096;
    for (int i = 0; i < 4096; i++) begin
      used_map[i] = 1'b1;
      rsv_map[i] = 1'b1;
    end
  end

  always @(posedge clk) begin
    grant_t a;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) n_active = cfg_data;
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        a.status = out_tdata[2:0];
        a.page   = out_tdata[14:3];
        a.last   = out_tlast;
        a.rsv    = out_tdata[15];
        a.used   = out_tdata[16];
        if (expected_grants.size() == 0) begin
          $error("result with nothing expected: status %0d page %0d", a.status, a.page);
          fail_count++;
        end else compare(expected_grants.pop_front(), a);
      end
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb import bpfa_pkg::*;;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  // page[11:0], count[24:12], dense[25], use_hint[26], mark_unavailable[27], zero[31:28]
  logic [31:0]      in_tdata;
  // operation[2:0]
  logic [OP_W-1:0]  in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  // status[2:0], granted_page[14:3], reserved_flag[15], used_flag[16], zero[23:17]
  logic [23:0]      out_tdata;
  logic             out_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  int  fail_count;
  int  pending;
  int  cycle_no;
  // receiver hold-off request and its length in cycles
  bit  hold_req;
  int  hold_len;
  bit  rx_free;      // drain with no stalls

  bitmap_page_frame_allocator i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  bpfa_checker i_chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: worst case is a full 4096-page scan per acquire, plus receiver stalls;
  // the limit is several times that over for ~250 requests.
  initial begin
    cycle_no = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no > 8000000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall before each result, long hold-off on request.
  initial begin
    int wait_n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_n = rx_free ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // One request on the input channel; a random gap first unless no_gap is set.
  task automatic send_req(logic [2:0] op, logic [11:0] pg, logic [12:0] cnt,
                          logic dense, logic use_h, logic mark, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, mark, use_h, dense, cnt, pg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let the channels settle before any register write
    repeat (20) @(posedge clk);
  endtask

  task automatic write_active(logic [12:0] v);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request, biased toward a live page window so acquire and release
  // actually hit free and used pages.
  task automatic random_req(int win, bit no_gap);
    int r;
    logic [2:0] op;
    logic [11:0] pg;
    logic [12:0] cnt;
    logic dn, uh, mk;
    r = $urandom_range(0, 99);
    if (r < 10)      op = OP_SET_RANGE;
    else if (r < 45) op = OP_ACQUIRE;
    else if (r < 70) op = OP_RELEASE;
    else if (r < 78) op = OP_RESERVE;
    else if (r < 84) op = OP_SET_HINT;
    else if (r < 96) op = OP_QUERY;
    else             op = 3'($urandom_range(6, 7));
    pg = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, win - 1));
    if (op == OP_SET_RANGE)
      cnt = ($urandom_range(0, 19) == 0) ? 13'($urandom) : 13'($urandom_range(0, 24));
    else if (op == OP_ACQUIRE)
      cnt = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 17));
    else cnt = 13'($urandom);
    dn = 1'($urandom_range(0, 1));
    uh = 1'($urandom_range(0, 1));
    mk = (op == OP_SET_RANGE) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
    send_req(op, pg, cnt, dn, uh, mk, no_gap);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    hold_req  = 1'b0;
    hold_len  = 0;
    rx_free   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset size: everything starts used and reserved.
    send_req(OP_ACQUIRE,   12'd0,    13'd4,    0, 1, 0, 0); // none free
    send_req(OP_RELEASE,   12'd5,    13'd0,    0, 0, 0, 0); // reserved page
    send_req(OP_SET_RANGE, 12'd4090, 13'd10,   0, 0, 0, 0); // overflow
    send_req(OP_SET_RANGE, 12'd0,    13'd0,    0, 0, 0, 0); // zero count, hint stays 0
    send_req(OP_SET_RANGE, 12'd8,    13'd40,   0, 0, 0, 0); // opens 8..47, captures hint
    send_req(OP_SET_RANGE, 12'd20,   13'd3,    0, 0, 1, 0); // gap 20..22
    send_req(OP_ACQUIRE,   12'd0,    13'd0,    0, 0, 0, 0); // zero count
    send_req(OP_ACQUIRE,   12'd0,    13'd8191, 1, 0, 0, 0); // dense, capped, restarts at gap
    send_req(OP_ACQUIRE,   12'd46,   13'd5,    0, 1, 0, 0); // sparse, wraps
    send_req(OP_QUERY,     12'd8,    13'd0,    0, 0, 0, 0);
    send_req(OP_QUERY,     12'd30,   13'd0,    0, 0, 0, 0);
    send_req(OP_RELEASE,   12'd30,   13'd0,    0, 0, 0, 0);
    send_req(OP_RELEASE,   12'd30,   13'd0,    0, 0, 0, 0); // not acquired
    send_req(OP_RESERVE,   12'd30,   13'd0,    0, 0, 0, 0); // not used
    send_req(OP_RESERVE,   12'd40,   13'd0,    0, 0, 0, 0);
    send_req(OP_SET_HINT,  12'd4095, 13'd0,    0, 0, 0, 0);
    send_req(OP_ACQUIRE,   12'd4095, 13'd1,    1, 1, 0, 0);
    send_req(3'd6,         12'd1,    13'd0,    0, 0, 0, 0);
    send_req(3'd7,         12'hFFF,  13'h1FFF, 1, 1, 1, 0);
    send_req(OP_SET_RANGE, 12'd4032, 13'd64,   0, 0, 0, 0); // open the top
    send_req(OP_ACQUIRE,   12'd4090, 13'd16,   1, 1, 0, 0); // dense, wraps past the top and restarts at each gap

    // Small window: out-of-range paths and wrap near the top.
    write_active(13'd1);
    send_req(OP_QUERY,     12'd1,    13'd0,    0, 0, 0, 0);
    send_req(OP_SET_RANGE, 12'd0,    13'd1,    0, 0, 0, 0);
    send_req(OP_ACQUIRE,   12'd0,    13'd3,    0, 1, 0, 0);
    send_req(OP_ACQUIRE,   12'd1,    13'd3,    0, 1, 0, 0);
    write_active(13'd8191);  // above the maximum acts as the maximum
    for (int i = 0; i < 20; i++) random_req(64, 0);
    write_active(13'd0);     // every page out of range
    for (int i = 0; i < 6; i++) random_req(16, 0);

    write_active(13'd96);
    // Long receiver hold-off while requests keep coming.
    hold_len = 300;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) random_req(96, 1);
    for (int i = 0; i < 60; i++) random_req(96, 0);
    // Sender waits for everything to drain, then a burst with no stalls.
    go_idle();
    rx_free = 1'b1;
    for (int i = 0; i < 20; i++) random_req(96, 1);
    rx_free = 1'b0;

    write_active(13'd33);
    for (int i = 0; i < 50; i++) random_req(33, 0);
    write_active(13'd4096);
    for (int i = 0; i < 50; i++) random_req(200, 0);

    go_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
